// ===== hw/rtl/wmrs_pkg.sv =====
// Shared types, constants and helpers for the wiper motor run sequencer.
package wmrs_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int SUB_W = $clog2(TICKS_PER_SECOND + 1);

    localparam logic [7:0] POWER_MAX = 8'd255;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_FULL = 2'd1,
        OP_TIE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_START_POWER = 2'd0,
        CFG_MIN_SECONDS = 2'd1,
        CFG_MAX_SECONDS = 2'd2,
        CFG_RAMP_DELAY  = 2'd3
    } cfg_idx_t;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_ONE  = 2'd1;
    localparam logic [1:0] DIR_TWO  = 2'd2;

    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_BLINK = 2'd1;
    localparam logic [1:0] LED_FAULT = 2'd2;

    localparam logic [7:0] RST_START_POWER = 8'd100;
    localparam logic [7:0] RST_MIN_SECONDS = 8'd2;
    localparam logic [7:0] RST_MAX_SECONDS = 8'd10;
    localparam logic [7:0] RST_RAMP_DELAY  = 8'd20;

    typedef struct packed {
        logic       button_pressed;
        logic       end_switch_closed;
        logic [1:0] operation;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kept_direction;
        logic       safe_end;
        logic       run_done;
        logic [1:0] led_mode;
        logic       motor_on;
        logic [1:0] motor_direction;
        logic [7:0] motor_power;
    } out_item_t;

    function automatic logic [1:0] flip_dir(input logic [1:0] d);
        logic [1:0] r;
        begin
            r = DIR_NONE;
            if (d == DIR_ONE)
            begin
                r = DIR_TWO;
            end
            else if (d == DIR_TWO)
            begin
                r = DIR_ONE;
            end
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/wmrs_core.sv =====
// Run state, configuration registers and per-request update logic.
module wmrs_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 step,
    input  wmrs_pkg::in_item_t   item,
    output wmrs_pkg::out_item_t  result
);
    import wmrs_pkg::*;

    logic [7:0]       start_power_reg, min_seconds_reg, max_seconds_reg, ramp_delay_reg;
    logic             running_reg, running_next;
    logic             tie_up_reg, tie_up_next;
    logic [1:0]       active_dir_reg, active_dir_next;
    logic [1:0]       stored_dir_reg, stored_dir_next;
    logic [7:0]       power_reg, power_next;
    logic [7:0]       ramp_reg, ramp_next;
    logic [SUB_W-1:0] sub_reg, sub_next;
    logic [7:0]       elapsed_reg, elapsed_next;
    logic             fault_reg, fault_next;
    logic             start, stop, safe, done;
    logic [SUB_W-1:0] sub_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_power_reg <= RST_START_POWER;
            min_seconds_reg <= RST_MIN_SECONDS;
            max_seconds_reg <= RST_MAX_SECONDS;
            ramp_delay_reg  <= RST_RAMP_DELAY;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_POWER: start_power_reg <= cfg_data;
                CFG_MIN_SECONDS: min_seconds_reg <= cfg_data;
                CFG_MAX_SECONDS: max_seconds_reg <= cfg_data;
                CFG_RAMP_DELAY:  ramp_delay_reg  <= cfg_data;
                default:         ramp_delay_reg  <= ramp_delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            tie_up_reg     <= 1'b0;
            active_dir_reg <= DIR_NONE;
            stored_dir_reg <= DIR_ONE;
            power_reg      <= '0;
            ramp_reg       <= '0;
            sub_reg        <= '0;
            elapsed_reg    <= '0;
            fault_reg      <= 1'b0;
        end
        else if (step)
        begin
            running_reg    <= running_next;
            tie_up_reg     <= tie_up_next;
            active_dir_reg <= active_dir_next;
            stored_dir_reg <= stored_dir_next;
            power_reg      <= power_next;
            ramp_reg       <= ramp_next;
            sub_reg        <= sub_next;
            elapsed_reg    <= elapsed_next;
            fault_reg      <= fault_next;
        end
    end

    assign start   = !running_reg && (item.operation inside {OP_FULL, OP_TIE});
    assign sub_inc = sub_reg + SUB_W'(1);

    always_comb
    begin
        running_next    = running_reg;
        tie_up_next     = tie_up_reg;
        active_dir_next = active_dir_reg;
        stored_dir_next = stored_dir_reg;
        power_next      = power_reg;
        ramp_next       = ramp_reg;
        sub_next        = sub_reg;
        elapsed_next    = elapsed_reg;
        fault_next      = fault_reg;
        stop            = 1'b0;
        safe            = 1'b0;
        done            = 1'b0;

        if (start)
        begin
            running_next    = 1'b1;
            tie_up_next     = (item.operation == OP_TIE);
            active_dir_next = (item.operation == OP_TIE) ? flip_dir(stored_dir_reg)
                                                         : stored_dir_reg;
            power_next      = start_power_reg;
            ramp_next       = '0;
            sub_next        = '0;
            elapsed_next    = '0;
            fault_next      = 1'b0;
        end
        else if (running_reg)
        begin
            sub_next = sub_inc;
            if (sub_inc >= SUB_W'(TICKS_PER_SECOND))
            begin
                sub_next = '0;
                if (elapsed_reg != COUNT_MAX)
                begin
                    elapsed_next = elapsed_reg + 8'd1;
                end
            end
            if (ramp_reg != COUNT_MAX)
            begin
                ramp_next = ramp_reg + 8'd1;
            end
        end

        if (start || running_reg)
        begin
            safe = (elapsed_next >= min_seconds_reg) && item.end_switch_closed;
            stop = (elapsed_next >= max_seconds_reg) || safe || item.button_pressed;
            if ((power_next != POWER_MAX) && (ramp_next >= ramp_delay_reg))
            begin
                ramp_next  = '0;
                power_next = power_next + 8'd1;
            end
            if (stop)
            begin
                done         = 1'b1;
                running_next = 1'b0;
                if (safe)
                begin
                    if (!tie_up_next)
                    begin
                        stored_dir_next = flip_dir(active_dir_next);
                    end
                end
                else
                begin
                    fault_next = 1'b1;
                end
                power_next      = '0;
                active_dir_next = DIR_NONE;
            end
        end
    end

    always_comb
    begin
        result.motor_power     = running_next ? power_next : 8'd0;
        result.motor_direction = running_next ? active_dir_next : DIR_NONE;
        result.motor_on        = running_next;
        result.led_mode        = running_next ? LED_BLINK : (fault_next ? LED_FAULT : LED_OFF);
        result.run_done        = done;
        result.safe_end        = done && safe;
        result.kept_direction  = stored_dir_next;
    end

endmodule

// ===== hw/rtl/wiper_motor_run_sequencer.sv =====
// Top level: input register, run sequencer core and output register.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | s_tdata[7:0]  request (tick or start)
//  m_*     | out | m_tvalid / m_tready | m_tdata[23:0] result, fields in [16:0]
//  cfg_*   | in  | cfg_we              | cfg_index[1:0], cfg_data[7:0]
//
// One request per clock unless m_tready stalls; results leave via the output register.
// The core state advances in the cycle a request moves from input to output register.
// rst_n clears both stages; config registers return to their defaults.
// A stalled m_tready holds the output; the input register still fills once.
module wiper_motor_run_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // operation[1:0], end_switch_closed[2], button_pressed[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // motor_power[7:0], motor_direction[9:8], motor_on[10],
                                   // led_mode[12:11], run_done[13], safe_end[14],
                                   // kept_direction[16:15]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import wmrs_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      advance, fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_t'(s_tdata[3:0]);
        end
        if (fire)
        begin
            out_item_reg <= core_result;
        end
    end

    wmrs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (fire),
        .item      (in_item_reg),
        .result    (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_item_reg};

endmodule

// ===== hw/rtl/wmrs_checker.sv =====
// Port-level assertions for the wiper motor run sequencer, bound to the top level.
module wmrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import wmrs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_safe_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> m_tdata[13])
        else $error("safe_end without run_done");

    a_on_led: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> (m_tdata[12:11] == LED_BLINK) && !m_tdata[13])
        else $error("running result with wrong led or done flag");

    a_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[10] |-> (m_tdata[7:0] == 8'd0) && (m_tdata[9:8] == DIR_NONE))
        else $error("power or direction while motor off");

endmodule

bind wiper_motor_run_sequencer wmrs_checker u_wmrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb.sv =====
// Stream-level testbench for the wiper motor run sequencer, with a cycle-free scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wmrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_AT_RESULT = 200;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // operation[1:0], end_switch_closed[2], button_pressed[3]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // motor_power[7:0], motor_direction[9:8], motor_on[10],
                            // led_mode[12:11], run_done[13], safe_end[14],
                            // kept_direction[16:15]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    wiper_motor_run_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting for the driver, results waiting for the monitor.
    logic [7:0] wipe_requests[$];
    out_item_t  expected_results[$];

    int  requests_queued;
    int  requests_taken;
    int  results_seen;
    int  error_count;
    int  idle_cycles;
    int  s_gap;
    int  r_gap;
    int  hold_left;
    bit  hold_done;
    bit  quiet;
    bit  s_fired;

    // Shadow configuration.
    logic [7:0] cfg_start_power;
    logic [7:0] cfg_min_secs;
    logic [7:0] cfg_max_secs;
    logic [7:0] cfg_ramp_delay;

    // Shadow sequencer state.
    logic        run_active;
    logic        tie_up;
    logic [1:0]  drive_dir;
    logic [1:0] kept_dir;
    logic [7:0]  power_now;
    logic [7:0]  ramp_count;
    logic [15:0] tick_count;
    logic [7:0]  secs_count;
    logic        fault_on;

    function automatic logic [1:0] toggled_dir(input logic [1:0] d);
        logic [1:0] r;
        begin
            case (d)
                DIR_ONE: r = DIR_TWO;
                DIR_TWO: r = DIR_ONE;
                default: r = DIR_NONE;
            endcase
            return r;
        end
    endfunction

    task automatic report(input string msg);
        begin
            $display("[%0t] %s", $realtime, msg);
            error_count++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        begin
            if (got !== want)
            begin
                report($sformatf("result %0d %s: got %0d, want %0d",
                                 results_seen, name, got, want));
            end
        end
    endtask

    task automatic predict_wipe(input logic [7:0] req);
        logic [1:0] op;
        logic       sw;
        logic       btn;
        logic       evaluate;
        logic       stop;
        logic       safe;
        logic       done;
        out_item_t  res;
        begin
            op       = req[1:0];
            sw       = req[2];
            btn      = req[3];
            evaluate = 1'b0;
            stop     = 1'b0;
            safe     = 1'b0;
            done     = 1'b0;
            if (!run_active && (op == OP_FULL || op == OP_TIE))
            begin
                run_active = 1'b1;
                tie_up     = (op == OP_TIE);
                drive_dir  = tie_up ? toggled_dir(kept_dir) : kept_dir;
                power_now  = cfg_start_power;
                ramp_count = '0;
                tick_count = '0;
                secs_count = '0;
                fault_on   = 1'b0;
                evaluate   = 1'b1;
            end
            else if (run_active)
            begin
                tick_count = tick_count + 16'd1;
                if (tick_count >= TICKS_PER_SECOND)
                begin
                    tick_count = '0;
                    if (secs_count < COUNT_MAX)
                    begin
                        secs_count = secs_count + 8'd1;
                    end
                end
                if (ramp_count < COUNT_MAX)
                begin
                    ramp_count = ramp_count + 8'd1;
                end
                evaluate = 1'b1;
            end
            if (evaluate)
            begin
                if (secs_count >= cfg_max_secs)
                begin
                    stop = 1'b1;
                end
                if (secs_count >= cfg_min_secs && sw)
                begin
                    safe = 1'b1;
                    stop = 1'b1;
                end
                if (power_now < POWER_MAX && ramp_count >= cfg_ramp_delay)
                begin
                    ramp_count = '0;
                    power_now  = power_now + 8'd1;
                end
                if (btn)
                begin
                    stop = 1'b1;
                end
                if (stop)
                begin
                    done       = 1'b1;
                    run_active = 1'b0;
                    if (safe)
                    begin
                        if (!tie_up)
                        begin
                            kept_dir = toggled_dir(drive_dir);
                        end
                    end
                    else
                    begin
                        fault_on = 1'b1;
                    end
                    power_now = '0;
                    drive_dir = DIR_NONE;
                end
            end
            res.motor_power     = run_active ? power_now : 8'd0;
            res.motor_direction = run_active ? drive_dir : DIR_NONE;
            res.motor_on        = run_active;
            res.led_mode        = run_active ? LED_BLINK : (fault_on ? LED_FAULT : LED_OFF);
            res.run_done        = done;
            res.safe_end        = done && safe;
            res.kept_direction  = kept_dir;
            expected_results.push_back(res);
        end
    endtask

    task automatic push_req(input logic [1:0] op, input logic sw, input logic btn);
        begin
            wipe_requests.push_back({4'b0000, btn, sw, op});
            requests_queued++;
        end
    endtask

    task automatic drain();
        begin
            while (requests_taken != requests_queued || expected_results.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            case (idx)
                CFG_START_POWER: cfg_start_power = val;
                CFG_MIN_SECONDS: cfg_min_secs    = val;
                CFG_MAX_SECONDS: cfg_max_secs    = val;
                default:         cfg_ramp_delay  = val;
            endcase
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic configure(input logic [7:0] sp, input logic [7:0] mn,
                             input logic [7:0] mx, input logic [7:0] rd);
        begin
            drain();
            write_reg(CFG_START_POWER, sp);
            write_reg(CFG_MIN_SECONDS, mn);
            write_reg(CFG_MAX_SECONDS, mx);
            write_reg(CFG_RAMP_DELAY, rd);
        end
    endtask

    // Mostly complete runs with random content, the rest loose requests.
    task automatic random_traffic(input int n);
        int budget;
        int len;
        begin
            budget = requests_queued + n;
            while (requests_queued < budget)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    push_req(2'($urandom_range(1, 2)), $urandom_range(0, 7) == 0, 1'b0);
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 30);
                    repeat (len)
                    begin
                        push_req(($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3))
                                                              : OP_TICK,
                                 $urandom_range(0, 31) == 0, $urandom_range(0, 63) == 0);
                    end
                    case ($urandom_range(0, 3))
                        0: push_req(OP_TICK, 1'b1, 1'b0);
                        1: push_req(OP_TICK, 1'b0, 1'b1);
                        2: push_req(OP_TICK, 1'b1, 1'b1);
                        default: ;
                    endcase
                end
                else
                begin
                    repeat ($urandom_range(1, 5))
                    begin
                        push_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    end
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Request driver.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fired))
        begin
            if (s_gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_gap    <= s_gap - 1;
            end
            else if (wipe_requests.size() == 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                s_tvalid <= 1'b0;
                s_gap    <= $urandom_range(1, 10) - 1;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= wipe_requests.pop_front();
            end
        end
    end

    // Result backpressure, with one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (r_gap > 0)
            begin
                r_gap    <= r_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                r_gap    <= $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Request and result monitor, watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            s_fired <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                predict_wipe(s_tdata);
                requests_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report($sformatf("result %0d with no request pending: %h",
                                     results_seen, m_tdata));
                end
                else
                begin
                    out_item_t got;
                    out_item_t want;
                    got  = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
                    want = expected_results.pop_front();
                    check_field("motor_power", got.motor_power, want.motor_power);
                    check_field("motor_direction", got.motor_direction, want.motor_direction);
                    check_field("motor_on", got.motor_on, want.motor_on);
                    check_field("led_mode", got.led_mode, want.led_mode);
                    check_field("run_done", got.run_done, want.run_done);
                    check_field("safe_end", got.safe_end, want.safe_end);
                    check_field("kept_direction", got.kept_direction, want.kept_direction);
                end
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_START_POWER;
        cfg_data        = '0;
        requests_queued = 0;
        requests_taken  = 0;
        results_seen    = 0;
        error_count     = 0;
        idle_cycles     = 0;
        s_gap           = 0;
        r_gap           = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        quiet           = 1'b0;
        s_fired         = 1'b0;
        cfg_start_power = RST_START_POWER;
        cfg_min_secs    = RST_MIN_SECONDS;
        cfg_max_secs    = RST_MAX_SECONDS;
        cfg_ramp_delay  = RST_RAMP_DELAY;
        run_active      = 1'b0;
        tie_up          = 1'b0;
        drive_dir       = DIR_NONE;
        kept_dir        = DIR_ONE;
        power_now       = '0;
        ramp_count      = '0;
        tick_count      = '0;
        secs_count      = '0;
        fault_on        = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: ignored inputs while idle, odd op codes, restart, button fault.
        push_req(OP_TICK, 1'b1, 1'b1);
        push_req(2'd3, 1'b0, 1'b0);
        push_req(OP_FULL, 1'b1, 1'b0);
        push_req(OP_TICK, 1'b1, 1'b0);
        push_req(2'd3, 1'b0, 1'b0);
        push_req(OP_TIE, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b0, 1'b1);
        push_req(OP_TICK, 1'b0, 1'b0);
        push_req(OP_TIE, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b1, 1'b1);

        // Zero time limits: start ends at once, safe or not.
        configure(8'd255, 8'd0, 8'd0, 8'd0);
        push_req(OP_FULL, 1'b0, 1'b0);
        push_req(OP_FULL, 1'b1, 1'b0);
        push_req(OP_TIE, 1'b1, 1'b0);
        push_req(OP_FULL, 1'b1, 1'b1);

        // Ramp on every item from zero power.
        configure(8'd0, 8'd0, 8'd255, 8'd0);
        push_req(OP_FULL, 1'b0, 1'b0);
        repeat (5) push_req(OP_TICK, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b1, 1'b0);

        // End switch locked out; slowest ramp.
        configure(8'd0, 8'd255, 8'd255, 8'd255);
        push_req(OP_TIE, 1'b1, 1'b0);
        push_req(OP_TICK, 1'b1, 1'b0);
        push_req(OP_TICK, 1'b0, 1'b1);

        // One run across a whole second: switch ignored until the second rolls over,
        // then end switch and time limit meet on the same tick.
        configure(8'd250, 8'd1, 8'd1, 8'd3);
        push_req(OP_FULL, 1'b1, 1'b0);
        repeat (998) push_req(OP_TICK, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b1, 1'b0);
        push_req(OP_TICK, 1'b1, 1'b0);

        // Random settings and traffic.
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
            begin
                drain();
                quiet = 1'b1;
            end
            configure(($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255)
                                                  : 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0,
                      ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                      ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3))
                                                  : (($urandom_range(0, 3) == 0) ? 8'd255
                                                     : 8'($urandom_range(0, 40))));
            random_traffic(10);
        end

        drain();
        repeat (10) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            report($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
